FILE: sv/assert_macros.svh
// Assertion helpers, included by sine_cosine_taylor_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
	else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	`ASSERT_AT(lbl, clk, rstn, !(expr))

`endif

FILE: sv/sct_pkg.sv
package sct_pkg;

	localparam int MAX_TERMS = 21;
	localparam int TERMS = 21;
	localparam int DW = 52;
	localparam int FRAC = 40;
	localparam int OW = 32;

	typedef logic signed [DW-1:0] q40_t;

	localparam q40_t HALF_PI = 52'sh001921FB54443;
	localparam q40_t TWO_PI = 52'sh006487ED5110B;
	localparam logic [OW-1:0] ONE_Q30 = 32'h4000_0000;

	// Odd Taylor coefficients (-1)^k / (2k+1)! in Q12.40, rounded to nearest.
	localparam q40_t COEF [MAX_TERMS] = '{
		52'sd1099511627776,
		-52'sd183251937963,
		52'sd9162596898,
		-52'sd218157069,
		52'sd3029959,
		-52'sd27545,
		52'sd177,
		-52'sd1,
		52'sd0, 52'sd0, 52'sd0, 52'sd0, 52'sd0, 52'sd0, 52'sd0,
		52'sd0, 52'sd0, 52'sd0, 52'sd0, 52'sd0, 52'sd0
	};

	typedef struct packed {
		logic vld;
		q40_t th;
		q40_t th2;
		q40_t acc;
	} lane_t;

endpackage

FILE: sv/sct_if.sv
interface sct_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic signed [31:0] angle;
	modport src(output valid, output cmd, output angle, input ready);
	modport snk(input valid, input cmd, input angle, output ready);
endinterface

interface sct_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] value;
	modport src(output valid, output value, input ready);
	modport snk(input valid, input value, output ready);
endinterface

FILE: sv/sct_reduce.sv
module sct_reduce (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld,
	input  logic cmd,
	input  logic signed [31:0] angle,
	output sct_pkg::lane_t lane
);

	sct_pkg::q40_t a_s1;
	logic vld_s1;
	sct_pkg::q40_t a_ext;
	sct_pkg::q40_t plus_w;
	sct_pkg::q40_t minus_w;
	sct_pkg::q40_t th_w;
	sct_pkg::q40_t th_s2;
	logic vld_s2;

	assign a_ext = {{(sct_pkg::DW-44){angle[31]}}, angle, 12'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	// The angle stays within two turns of the range, so a single add or
	// subtract of one or two turns reaches [0, 2pi).
	assign plus_w = a_s1 + sct_pkg::TWO_PI;
	assign minus_w = a_s1 - sct_pkg::TWO_PI;

	always_comb begin
		priority if (a_s1 < 0) begin
			th_w = (plus_w < 0) ? plus_w + sct_pkg::TWO_PI : plus_w;
		end else if (a_s1 >= sct_pkg::TWO_PI) begin
			th_w = minus_w;
		end else begin
			th_w = a_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= cmd ? a_ext + sct_pkg::HALF_PI : a_ext;
			th_s2 <= th_w;
		end
	end

	always_comb begin
		lane = '0;
		lane.vld = vld_s2;
		lane.th = th_s2;
	end

endmodule

FILE: sv/sct_cell.sv
module sct_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  sct_pkg::lane_t lane_i,
	input  sct_pkg::q40_t mul_a,
	input  sct_pkg::q40_t mul_b,
	input  sct_pkg::q40_t addend,
	output sct_pkg::lane_t lane_o,
	output sct_pkg::q40_t res
);

	localparam int LW = 26;
	localparam int HW = sct_pkg::DW - 1 - LW;
	localparam int PW = 2 * sct_pkg::DW;

	logic [sct_pkg::DW-1:0] ma;
	logic [sct_pkg::DW-1:0] mb;
	logic [2*LW-1:0] ll_s1;
	logic [LW+HW-1:0] lh_s1;
	logic [LW+HW-1:0] hl_s1;
	logic [2*HW-1:0] hh_s1;
	logic neg_s1;
	sct_pkg::q40_t add_s1;
	sct_pkg::lane_t lane_s1;
	logic [PW-1:0] sum_w;
	logic [sct_pkg::DW-1:0] mag_w;
	sct_pkg::q40_t res_s2;
	sct_pkg::lane_t lane_s2;
	logic vld_s1;
	logic vld_s2;

	assign ma = mul_a[sct_pkg::DW-1] ? -mul_a : mul_a;
	assign mb = mul_b[sct_pkg::DW-1] ? -mul_b : mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= lane_i.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= ma[LW-1:0] * mb[LW-1:0];
			lh_s1 <= ma[LW-1:0] * mb[LW+HW-1:LW];
			hl_s1 <= ma[LW+HW-1:LW] * mb[LW-1:0];
			hh_s1 <= ma[LW+HW-1:LW] * mb[LW+HW-1:LW];
			neg_s1 <= mul_a[sct_pkg::DW-1] ^ mul_b[sct_pkg::DW-1];
			add_s1 <= addend;
			lane_s1 <= lane_i;
			res_s2 <= add_s1 + (neg_s1 ? -sct_pkg::q40_t'(mag_w) : sct_pkg::q40_t'(mag_w));
			lane_s2 <= lane_s1;
		end
	end

	// Magnitude product rounded half up, so the signed result rounds
	// ties away from zero.
	assign sum_w = PW'(ll_s1) + (PW'(lh_s1) << LW) + (PW'(hl_s1) << LW)
		+ (PW'(hh_s1) << (2 * LW)) + (PW'(1) << (sct_pkg::FRAC - 1));
	assign mag_w = sum_w[sct_pkg::FRAC +: sct_pkg::DW];

	always_comb begin
		lane_o = lane_s2;
		lane_o.vld = vld_s2;
	end
	assign res = res_s2;

endmodule

FILE: sv/sine_cosine_taylor_unit.sv
// Fixed-point sine and cosine by a Taylor series.
// Channel req carries cmd (0 sine, 1 cosine) and a signed Q4.28 angle in
// radians; channel rsp returns value, the result in signed Q2.30, saturated
// to plus or minus one. Both use valid/ready; a beat moves when both are high.
// Cosine adds pi/2, the angle is reduced into [0, 2pi), and the odd series is
// evaluated by Horner in the squared angle along a chain of multiply-add
// cells, each two stages deep: one for the square, TERMS-1 Horner steps and
// one final product.
// rsp valid is registered at the output, behind the reduction stages and the
// cell chain. One item is accepted every cycle while the receiver keeps up.
// Reset clears all valid flags; no result is pending after it.
// When the receiver stalls, the output register holds its beat and a skid
// register takes one more result; once that is full the chain freezes and
// req.ready drops until the output drains.
`include "assert_macros.svh"

module sine_cosine_taylor_unit #(
	parameter int TERMS = sct_pkg::TERMS
) (
	input  logic clk,
	input  logic arst_n,
	sct_in_if.snk req,
	sct_out_if.src rsp
);

	localparam int NCELL = TERMS + 1;

	sct_pkg::lane_t lane_w [NCELL+1];
	logic en;
	logic take;
	sct_pkg::q40_t t_w;
	logic [sct_pkg::DW-1:0] tmag_w;
	logic [sct_pkg::DW-11:0] rmag_w;
	logic [sct_pkg::OW-1:0] cmag_w;
	logic signed [sct_pkg::OW-1:0] r_w;
	logic out_vld_q;
	logic signed [sct_pkg::OW-1:0] out_val_q;
	logic skid_vld_q;
	logic signed [sct_pkg::OW-1:0] skid_val_q;

	assign en = !skid_vld_q;
	assign req.ready = en;
	assign take = out_vld_q && rsp.ready;

	sct_reduce u_reduce (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld(req.valid),
		.cmd(req.cmd),
		.angle(req.angle),
		.lane(lane_w[0])
	);

	for (genvar j = 0; j < NCELL; j++) begin : g_cell
		sct_pkg::lane_t lo;
		sct_pkg::q40_t res;
		sct_pkg::q40_t op_a;
		sct_pkg::q40_t op_b;
		sct_pkg::q40_t add;

		if (j == 0) begin : g_sq
			assign op_a = lane_w[j].th;
			assign op_b = lane_w[j].th;
			assign add = '0;
			always_comb begin
				lane_w[j+1] = lo;
				lane_w[j+1].th2 = res;
				lane_w[j+1].acc = sct_pkg::COEF[TERMS-1];
			end
		end else if (j < TERMS) begin : g_horner
			assign op_a = lane_w[j].th2;
			assign op_b = lane_w[j].acc;
			assign add = sct_pkg::COEF[TERMS-1-j];
			always_comb begin
				lane_w[j+1] = lo;
				lane_w[j+1].acc = res;
			end
		end else begin : g_final
			assign op_a = lane_w[j].th;
			assign op_b = lane_w[j].acc;
			assign add = '0;
			always_comb begin
				lane_w[j+1] = lo;
				lane_w[j+1].acc = res;
			end
		end

		sct_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.lane_i(lane_w[j]),
			.mul_a(op_a),
			.mul_b(op_b),
			.addend(add),
			.lane_o(lo),
			.res(res)
		);
	end

	assign t_w = lane_w[NCELL].acc;
	assign tmag_w = t_w[sct_pkg::DW-1] ? -t_w : t_w;
	assign rmag_w = (tmag_w[sct_pkg::DW-1:10]) + (sct_pkg::DW-10)'(tmag_w[9]);
	assign cmag_w = (rmag_w > (sct_pkg::DW-10)'(sct_pkg::ONE_Q30)) ?
		sct_pkg::ONE_Q30 : rmag_w[sct_pkg::OW-1:0];
	assign r_w = t_w[sct_pkg::DW-1] ? -cmag_w : cmag_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || take) begin
			if (skid_vld_q) begin
				out_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= lane_w[NCELL].vld;
			end
		end else if (en && lane_w[NCELL].vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || take) begin
			out_val_q <= skid_vld_q ? skid_val_q : r_w;
		end else if (en && lane_w[NCELL].vld) begin
			skid_val_q <= r_w;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.value = out_val_q;

	`ASSERT_NEVER(a_skid_without_out, clk, arst_n, skid_vld_q && !out_vld_q)
	`ASSERT_AT(a_value_range, clk, arst_n,
		out_vld_q |-> (out_val_q <= 32'sh4000_0000 && out_val_q >= -32'sh4000_0000))
	`ASSERT_AT(a_skid_holds, clk, arst_n,
		(skid_vld_q && !take) |=> (skid_vld_q && $stable(skid_val_q)))

endmodule
